// ===== sv/slpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slpg_pkg;

    // Action code carried on each pixel beat.
    typedef logic [1:0] t_action;

    localparam t_action ACT_WRITE  = 2'd0;
    localparam t_action ACT_INVERT = 2'd1;
    localparam t_action ACT_NONE   = 2'd2;

    // Write modes held for the line in progress.
    localparam logic [1:0] MODE_REPLACE     = 2'd0;
    localparam logic [1:0] MODE_TRANSPARENT = 2'd1;
    localparam logic [1:0] MODE_XOR         = 2'd2;
    localparam logic [1:0] MODE_REV_TRANSP  = 2'd3;

    // Request types.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam int COLOR_BITS = 16;
    localparam int MASK_BITS  = 16;

endpackage

`default_nettype wire

// ===== sv/styled_line_pixel_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A step beat's pixel is loaded into the output register by the edge that accepts the beat.
// Throughput: one input beat per cycle while o_in_stall is low; each step on an active line yields one pixel beat.
// The rate is set by the combinational error update (one add and one subtract with compare).
// A start beat yields no output beat; a step while no line is active yields nothing.
// Reset (i_rst_n low, synchronous) clears the active-line flag and the output valid.

module styled_line_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // Request channel.
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire                     i_req_type,
    input  wire  [COORD_BITS-1:0]   i_x_start,
    input  wire  [COORD_BITS-1:0]   i_y_start,
    input  wire  [COORD_BITS-1:0]   i_x_end,
    input  wire  [COORD_BITS-1:0]   i_y_end,
    input  wire  [1:0]              i_write_mode,
    input  wire  [15:0]             i_draw_color,
    input  wire  [15:0]             i_style_mask,
    // Pixel channel.
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic [COORD_BITS-1:0]   o_pixel_x,
    output logic [COORD_BITS-1:0]   o_pixel_y,
    output logic [1:0]              o_pixel_action,
    output logic [15:0]             o_pixel_value,
    output logic [15:0]             o_mask_after,
    output logic                    o_last_pixel
);

    // The stored error term lives in (-2^(C+1), 2^(C+1)), so it needs C+2 signed bits.
    // Increments are twice a delta, so C+1 bits. The pixel count reaches 2^C.
    localparam int EW = COORD_BITS + 2;
    localparam int IW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + 1;

    // Line state.
    logic                           r_busy;
    logic [COORD_BITS-1:0]          r_cur_x;
    logic [COORD_BITS-1:0]          r_cur_y;
    logic signed [EW-1:0]           r_err_term;
    logic [IW-1:0]                  r_err_inc;
    logic [IW-1:0]                  r_err_dec;
    logic [PW-1:0]                  r_pixels_left;
    logic                           r_x_major;
    logic                           r_y_down;
    logic [1:0]                     r_mode_held;
    logic [slpg_pkg::COLOR_BITS-1:0] r_color_held;
    logic [slpg_pkg::MASK_BITS-1:0]  r_mask_held;

    // Output register.
    logic                           r_out_valid;
    logic [COORD_BITS-1:0]          r_pixel_x;
    logic [COORD_BITS-1:0]          r_pixel_y;
    slpg_pkg::t_action              r_pixel_action;
    logic [15:0]                    r_pixel_value;
    logic [15:0]                    r_mask_after;
    logic                           r_last_pixel;

    // The output register can take a new beat when it is empty or being drained
    // in this cycle, so the request side keeps moving while each pixel is taken.
    logic out_free;
    logic in_accept;
    logic do_start;
    logic do_step;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_free;
    assign in_accept  = i_in_valid && out_free;
    assign do_start   = in_accept && (i_req_type == slpg_pkg::REQ_START);
    assign do_step    = in_accept && (i_req_type == slpg_pkg::REQ_STEP) && r_busy;

    // ------------------------------------------------------------------
    // Start setup: order endpoints so x never decreases, then take the
    // absolute deltas and pick the major axis. Equal deltas go x-major.
    // ------------------------------------------------------------------
    logic                  swap;
    logic [COORD_BITS-1:0] n_x0;
    logic [COORD_BITS-1:0] n_y0;
    logic [COORD_BITS-1:0] n_y1;
    logic [COORD_BITS-1:0] n_dx;
    logic [COORD_BITS-1:0] n_dy;
    logic                  n_y_down;
    logic                  n_x_major;
    logic [COORD_BITS-1:0] n_major;
    logic [COORD_BITS-1:0] n_minor;

    always_comb begin
        swap      = i_x_end < i_x_start;
        n_x0      = swap ? i_x_end   : i_x_start;
        n_y0      = swap ? i_y_end   : i_y_start;
        n_y1      = swap ? i_y_start : i_y_end;
        n_dx      = swap ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
        n_y_down  = n_y1 < n_y0;
        n_dy      = n_y_down ? (n_y0 - n_y1) : (n_y1 - n_y0);
        n_x_major = n_dx >= n_dy;
        n_major   = n_x_major ? n_dx : n_dy;
        n_minor   = n_x_major ? n_dy : n_dx;
    end

    // ------------------------------------------------------------------
    // Per-pixel work: rotate the style mask, pick the action from its new
    // bit 0 and the held mode, then advance the Bresenham walk.
    // ------------------------------------------------------------------
    logic [15:0]           n_mask;
    logic                  style_bit;
    slpg_pkg::t_action     n_action;
    logic [15:0]           n_value;
    logic                  n_last;
    logic signed [EW-1:0]  err_sum;
    logic signed [EW-1:0]  err_adj;
    logic                  minor_move;
    logic [COORD_BITS-1:0] y_stepped;
    logic [COORD_BITS-1:0] n_cur_x;
    logic [COORD_BITS-1:0] n_cur_y;
    logic signed [EW-1:0]  n_err_term;

    always_comb begin
        n_mask    = {r_mask_held[14:0], r_mask_held[15]};
        style_bit = n_mask[0];

        unique case (r_mode_held)
            slpg_pkg::MODE_REV_TRANSP: begin
                n_action = style_bit ? slpg_pkg::ACT_WRITE : slpg_pkg::ACT_NONE;
                n_value  = style_bit ? {8'h00, ~r_color_held[7:0]} : 16'h0000;
            end
            slpg_pkg::MODE_XOR: begin
                n_action = style_bit ? slpg_pkg::ACT_INVERT : slpg_pkg::ACT_NONE;
                n_value  = 16'h0000;
            end
            slpg_pkg::MODE_TRANSPARENT: begin
                n_action = style_bit ? slpg_pkg::ACT_WRITE : slpg_pkg::ACT_NONE;
                n_value  = style_bit ? r_color_held : 16'h0000;
            end
            default: begin
                n_action = slpg_pkg::ACT_WRITE;
                n_value  = style_bit ? r_color_held : 16'h0000;
            end
        endcase

        n_last = r_pixels_left <= PW'(1);

        // A non-negative sum means the minor axis moves this pixel.
        err_sum    = r_err_term + $signed({1'b0, r_err_inc});
        err_adj    = err_sum - $signed({1'b0, r_err_dec});
        minor_move = !err_sum[EW-1];
        n_err_term = minor_move ? err_adj : err_sum;

        y_stepped = r_y_down ? (r_cur_y - COORD_BITS'(1)) : (r_cur_y + COORD_BITS'(1));

        if (r_x_major) begin
            n_cur_x = r_cur_x + COORD_BITS'(1);
            n_cur_y = minor_move ? y_stepped : r_cur_y;
        end else begin
            n_cur_y = y_stepped;
            n_cur_x = minor_move ? (r_cur_x + COORD_BITS'(1)) : r_cur_x;
        end
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (do_start) begin
            r_busy <= 1'b1;
        end else if (do_step && n_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_cur_x       <= n_x0;
            r_cur_y       <= n_y0;
            r_y_down      <= n_y_down;
            r_x_major     <= n_x_major;
            r_err_term    <= -$signed({2'b00, n_major});
            r_err_inc     <= {n_minor, 1'b0};
            r_err_dec     <= {n_major, 1'b0};
            r_pixels_left <= {1'b0, n_major} + PW'(1);
            r_mode_held   <= i_write_mode;
            r_color_held  <= i_draw_color;
            r_mask_held   <= i_style_mask;
        end else if (do_step) begin
            r_mask_held <= n_mask;
            if (n_last) begin
                r_pixels_left <= '0;
            end else begin
                r_pixels_left <= r_pixels_left - PW'(1);
                r_cur_x       <= n_cur_x;
                r_cur_y       <= n_cur_y;
                r_err_term    <= n_err_term;
            end
        end
    end

    // Output register: loads on a productive step, drains when not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= do_step;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_pixel_x      <= r_cur_x;
            r_pixel_y      <= r_cur_y;
            r_pixel_action <= n_action;
            r_pixel_value  <= n_value;
            r_mask_after   <= n_mask;
            r_last_pixel   <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_pixel_action = r_pixel_action;
    assign o_pixel_value  = r_pixel_value;
    assign o_mask_after   = r_mask_after;
    assign o_last_pixel   = r_last_pixel;

endmodule

`default_nettype wire

// ===== sv/slpg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slpg_checker #(
    parameter int COORD_BITS = 12
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire [COORD_BITS-1:0] o_pixel_x,
    input wire [COORD_BITS-1:0] o_pixel_y,
    input wire [1:0]            o_pixel_action,
    input wire [15:0]           o_pixel_value,
    input wire [15:0]           o_mask_after,
    input wire                  o_last_pixel
);

    // A waiting pixel must hold the request side back, or a beat would be lost.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request accepted while a stalled pixel is pending");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_action == slpg_pkg::ACT_WRITE ||
                         o_pixel_action == slpg_pkg::ACT_INVERT ||
                         o_pixel_action == slpg_pkg::ACT_NONE))
        else $error("illegal pixel action");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pixel_action != slpg_pkg::ACT_WRITE) |-> (o_pixel_value == 16'h0000))
        else $error("pixel value nonzero on a non-write beat");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("pixel valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_pixel_x) && $stable(o_pixel_y) &&
            $stable(o_pixel_action) && $stable(o_pixel_value) &&
            $stable(o_mask_after) && $stable(o_last_pixel)))
        else $error("pixel payload changed while stalled");

endmodule

bind styled_line_pixel_generator slpg_checker #(.COORD_BITS(COORD_BITS)) u_slpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_pixel_action (o_pixel_action),
    .o_pixel_value  (o_pixel_value),
    .o_mask_after   (o_mask_after),
    .o_last_pixel   (o_last_pixel)
);

`default_nettype wire

// ===== test/styled_line_pixel_generator_tb.sv =====
`timescale 1ns / 1ps

module styled_line_pixel_generator_tb;

    localparam int CB = 12;

    // Generous cycle budget. A correct run is roughly 2100 input beats, each
    // of which may sit through a few sender idle cycles and a run of receiver
    // stalls, so this limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 400000;

    // One request beat, with every field at the port width.
    typedef struct packed {
        logic          req;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
        logic [1:0]    mode;
        logic [15:0]   color;
        logic [15:0]   mask;
    } t_line_req;

    // One pixel beat, as the block should present it.
    typedef struct packed {
        logic [CB-1:0]     x;
        logic [CB-1:0]     y;
        slpg_pkg::t_action action;
        logic [15:0]       value;
        logic [15:0]       mask;
        logic              last;
    } t_pixel;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic          i_req_type = slpg_pkg::REQ_START;
    logic [CB-1:0] i_x_start = '0;
    logic [CB-1:0] i_y_start = '0;
    logic [CB-1:0] i_x_end = '0;
    logic [CB-1:0] i_y_end = '0;
    logic [1:0]    i_write_mode = slpg_pkg::MODE_REPLACE;
    logic [15:0]   i_draw_color = '0;
    logic [15:0]   i_style_mask = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic [CB-1:0] o_pixel_x;
    logic [CB-1:0] o_pixel_y;
    logic [1:0]    o_pixel_action;
    logic [15:0]   o_pixel_value;
    logic [15:0]   o_mask_after;
    logic          o_last_pixel;

    styled_line_pixel_generator #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_write_mode  (i_write_mode),
        .i_draw_color  (i_draw_color),
        .i_style_mask  (i_style_mask),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_action(o_pixel_action),
        .o_pixel_value (o_pixel_value),
        .o_mask_after  (o_mask_after),
        .o_last_pixel  (o_last_pixel)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pixels predicted for accepted step beats, oldest first.
    t_pixel pending_pixels[$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     cycle_count = 0;

    // When clear, neither the sender nor the receiver inserts idle cycles.
    bit     gaps_on = 1'b0;

    // Our own copy of the line walker's state.
    bit            ln_busy = 1'b0;
    logic [CB-1:0] ln_x = '0;
    logic [CB-1:0] ln_y = '0;
    int            ln_err = 0;
    int            ln_inc = 0;
    int            ln_dec = 0;
    logic [12:0]   ln_left = '0;
    bit            ln_xmajor = 1'b0;
    bit            ln_ydown = 1'b0;
    logic [1:0]    ln_mode = slpg_pkg::MODE_REPLACE;
    logic [15:0]   ln_color = '0;
    logic [15:0]   ln_mask = '0;

    // Moves one row along the line's vertical direction, wrapping at the
    // coordinate width.
    function automatic logic [CB-1:0] next_row(input logic [CB-1:0] row);
        return ln_ydown ? row - 1'b1 : row + 1'b1;
    endfunction

    // Applies one request beat to the walker state. Returns 1 and fills px
    // when the beat should produce a pixel.
    function automatic bit predict_pixel(input t_line_req r, output t_pixel px);
        int   dx;
        int   dy;
        logic bit0;
        px = '0;
        if (r.req == slpg_pkg::REQ_START) begin
            // Order the endpoints so that x never decreases along the line.
            if (r.xe < r.xs) begin
                ln_x = r.xe;
                ln_y = r.ye;
                dx = int'(r.xs) - int'(r.xe);
                dy = int'(r.ys) - int'(r.ye);
            end else begin
                ln_x = r.xs;
                ln_y = r.ys;
                dx = int'(r.xe) - int'(r.xs);
                dy = int'(r.ye) - int'(r.ys);
            end
            ln_ydown = (dy < 0);
            if (dy < 0) dy = -dy;
            // A tie between the deltas counts as x-major.
            ln_xmajor = (dx >= dy);
            if (ln_xmajor) begin
                ln_err = -dx;
                ln_inc = 2 * dy;
                ln_dec = 2 * dx;
                ln_left = 13'(dx + 1);
            end else begin
                ln_err = -dy;
                ln_inc = 2 * dx;
                ln_dec = 2 * dy;
                ln_left = 13'(dy + 1);
            end
            ln_mode = r.mode;
            ln_color = r.color;
            ln_mask = r.mask;
            ln_busy = 1'b1;
            return 1'b0;
        end

        if (!ln_busy) return 1'b0;

        // The style mask rotates before its low bit is used.
        ln_mask = {ln_mask[14:0], ln_mask[15]};
        bit0 = ln_mask[0];
        case (ln_mode)
            slpg_pkg::MODE_REV_TRANSP: begin
                px.action = bit0 ? slpg_pkg::ACT_WRITE : slpg_pkg::ACT_NONE;
                if (bit0) px.value = {8'h00, ~ln_color[7:0]};
            end
            slpg_pkg::MODE_XOR: begin
                px.action = bit0 ? slpg_pkg::ACT_INVERT : slpg_pkg::ACT_NONE;
            end
            slpg_pkg::MODE_TRANSPARENT: begin
                px.action = bit0 ? slpg_pkg::ACT_WRITE : slpg_pkg::ACT_NONE;
                if (bit0) px.value = ln_color;
            end
            default: begin
                px.action = slpg_pkg::ACT_WRITE;
                px.value = bit0 ? ln_color : 16'h0000;
            end
        endcase
        px.x = ln_x;
        px.y = ln_y;
        px.mask = ln_mask;
        px.last = (ln_left <= 13'd1);
        if (px.last) begin
            ln_left = '0;
            ln_busy = 1'b0;
            return 1'b1;
        end
        ln_left = ln_left - 1'b1;

        // Major axis always advances; the minor one follows the error term.
        if (ln_xmajor) ln_x = ln_x + 1'b1;
        else ln_y = next_row(ln_y);
        ln_err += ln_inc;
        if (ln_err >= 0) begin
            ln_err -= ln_dec;
            if (ln_xmajor) ln_y = next_row(ln_y);
            else ln_x = ln_x + 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic t_line_req make_start(input logic [CB-1:0] xs, ys, xe, ye,
                                             input logic [1:0] mode,
                                             input logic [15:0] color, mask);
        t_line_req r;
        r.req = slpg_pkg::REQ_START;
        r.xs = xs;
        r.ys = ys;
        r.xe = xe;
        r.ye = ye;
        r.mode = mode;
        r.color = color;
        r.mask = mask;
        return r;
    endfunction

    // Every field random, the request type too. A step beat carries junk in
    // the line fields, which the block must ignore.
    function automatic t_line_req random_req();
        t_line_req r;
        r.req = 1'($urandom);
        r.xs = CB'($urandom);
        r.ys = CB'($urandom);
        r.xe = CB'($urandom);
        r.ye = CB'($urandom);
        r.mode = 2'($urandom);
        r.color = 16'($urandom);
        r.mask = 16'($urandom);
        return r;
    endfunction

    function automatic t_line_req step_req();
        t_line_req r;
        r = random_req();
        r.req = slpg_pkg::REQ_STEP;
        return r;
    endfunction

    function automatic int line_len(input t_line_req s);
        int dx;
        int dy;
        dx = int'(s.xe) - int'(s.xs);
        dy = int'(s.ye) - int'(s.ys);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    // A coordinate within span of base, clamped to the coordinate range.
    function automatic logic [CB-1:0] near(input logic [CB-1:0] base, input int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > (1 << CB) - 1) v = (1 << CB) - 1;
        return CB'(v);
    endfunction

    // Short line somewhere on the grid, now and then pinned to an edge.
    function automatic t_line_req short_start();
        int            span;
        logic [CB-1:0] bx;
        logic [CB-1:0] by;
        span = ($urandom_range(3) == 0) ? 2 : 16;
        bx = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : CB'($urandom);
        by = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : CB'($urandom);
        return make_start(bx, by, near(bx, span), near(by, span), 2'($urandom),
                          16'($urandom), 16'($urandom));
    endfunction

    // Sends one request beat. Inputs change only at the falling edge; the
    // beat is taken at the first rising edge that sees the stall low, and
    // the prediction is made right there.
    task automatic send_req(input t_line_req r);
        t_pixel px;
        bit     produced;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 34) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = r.req;
        i_x_start = r.xs;
        i_y_start = r.ys;
        i_x_end = r.xe;
        i_y_end = r.ye;
        i_write_mode = r.mode;
        i_draw_color = r.color;
        i_style_mask = r.mask;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        produced = predict_pixel(r, px);
        if (produced) pending_pixels.push_back(px);
        // Steps on an idle walker are ignored by the block and not counted.
        if (r.req == slpg_pkg::REQ_START || produced) items_sent++;
    endtask

    task automatic run_line(input t_line_req s, input int steps);
        send_req(s);
        repeat (steps) send_req(step_req());
    endtask

    // Drops the request valid first, so the beat last sent is not taken again.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Hand-picked lines covering the corners of the behavior.
    task automatic test_directed();
        gaps_on = 1'b1;
        // A step with no line loaded must not produce a beat.
        send_req(step_req());
        // A single-point line gives exactly one pixel; the extra step is idle.
        run_line(make_start('0, '0, '0, '0, slpg_pkg::MODE_REPLACE, 16'hFFFF, 16'h8000), 2);
        // Endpoints given right to left at the top edge of x, climbing down in
        // y with equal deltas: swapped, y decreasing, treated as x-major.
        run_line(make_start('1, '0, 12'd4093, 12'd2, slpg_pkg::MODE_TRANSPARENT,
                            16'h1234, 16'hAAAA), 3);
        // Steep line from the bottom edge of y, exclusive-or mode.
        run_line(make_start('0, '1, 12'd1, 12'd4092, slpg_pkg::MODE_XOR,
                            16'hFFFF, 16'h5555), 4);
        // Vertical line at the far corner, inverted low byte of the colour.
        run_line(make_start('1, '1, '1, 12'd4093, slpg_pkg::MODE_REV_TRANSP,
                            16'hFF00, 16'hFFFF), 3);
        // A new start drops the line in progress after two pixels.
        run_line(make_start('0, '0, 12'd10, 12'd3, slpg_pkg::MODE_REPLACE,
                            16'hC3A5, 16'h0F0F), 2);
        run_line(make_start(12'd20, 12'd20, 12'd17, 12'd25, slpg_pkg::MODE_TRANSPARENT,
                            16'hFFFF, 16'h0001), 6);
    endtask

    // Full-length diagonal across the grid, so the pixel counter is loaded
    // at its largest value. The first few hundred pixels are walked with
    // neither side idling, and the next start replaces the line.
    task automatic test_long_line();
        t_line_req s;
        gaps_on = 1'b0;
        s = make_start('0, '1, '1, '0, 2'($urandom), 16'($urandom), 16'($urandom));
        run_line(s, 300);
    endtask

    // The sender holds off mid-line until every predicted pixel has come out,
    // then finishes the line.
    task automatic test_drain_pause();
        gaps_on = 1'b1;
        run_line(make_start(12'd100, 12'd200, 12'd130, 12'd190, slpg_pkg::MODE_REPLACE,
                            16'h0F0F, 16'h3C3C), 10);
        wait_drained();
        repeat (21) send_req(step_req());
    endtask

    // Mostly complete short lines with random content, mixed with cut-off lines,
    // stray beats and long lines abandoned early.
    task automatic test_random_lines();
        int        first;
        int        kind;
        int        n;
        t_line_req s;
        first = items_sent;
        while (items_sent - first < 1600) begin
            gaps_on = ($urandom_range(9) != 0);
            kind = $urandom_range(99);
            s = short_start();
            n = line_len(s);
            if (kind < 70) begin
                run_line(s, n + $urandom_range(0, 1));
            end else if (kind < 85) begin
                run_line(s, $urandom_range(0, n - 1));
            end else if (kind < 95) begin
                send_req(random_req());
            end else begin
                s = random_req();
                s.req = slpg_pkg::REQ_START;
                run_line(s, $urandom_range(0, 40));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver side: stalls at random, decided at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall = gaps_on && ($urandom_range(99) < 34);
    end

    // Each pixel beat taken at a rising edge is compared with the oldest
    // prediction.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t ns: unexpected pixel beat: expected none, got (%0d,%0d)",
                         $time, o_pixel_x, o_pixel_y);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", 16'(want.x), 16'(o_pixel_x));
                check_field("pixel_y", 16'(want.y), 16'(o_pixel_y));
                check_field("pixel_action", 16'(want.action), 16'(o_pixel_action));
                check_field("pixel_value", want.value, o_pixel_value);
                check_field("mask_after", want.mask, o_mask_after);
                check_field("last_pixel", 16'(want.last), 16'(o_last_pixel));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** styled_line_pixel_generator: FAILED **");
            $finish;
        end
    end

    initial begin
        // Reset is synchronous, held low from time zero and released at a
        // falling edge.
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_long_line();
        test_drain_pause();
        test_random_lines();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait_drained();
        // A few more cycles catch any stray beat after the last pixel.
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** styled_line_pixel_generator: PASSED **");
        end else begin
            $display("** styled_line_pixel_generator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slpg_pkg.sv
sv/styled_line_pixel_generator.sv
sv/slpg_checker.sv
test/styled_line_pixel_generator_tb.sv
